/* rtl/bmp24_pkg.sv */
// bmp24_pkg: constants, codes and helpers for the 24-bit bitmap stream decoder
// no dependencies; imported by bmp24_stream_decoder_top
package bmp24_pkg;

	localparam int unsigned MAX_DIM = 4096;
	localparam int unsigned DIM_W = 13;      // holds 0..MAX_DIM
	localparam int unsigned COORD_W = 12;
	localparam int unsigned COUNT_W = 25;
	localparam int unsigned TDATA_W = 80;    // 74 payload bits rounded up to bytes

	localparam logic [COUNT_W-1:0] OPEN_MAX = {COUNT_W{1'b1}};

	// parser phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_PAD    = 3'd4;

	// result status codes
	localparam logic [2:0] ST_PIXEL     = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
	localparam logic [2:0] ST_BAD_HDR   = 3'd2;
	localparam logic [2:0] ST_NOT_24BPP = 3'd3;
	localparam logic [2:0] ST_COMPRESSED = 3'd4;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd5;

	localparam logic [7:0]  MAGIC_B   = 8'h42;
	localparam logic [7:0]  MAGIC_M   = 8'h4D;
	localparam logic [31:0] HDR_LONG  = 32'd40;
	localparam logic [31:0] HDR_SHORT = 32'd12;
	localparam logic [15:0] BPP_24    = 16'd24;

	// valid dimension passes, anything else becomes zero
	function automatic logic [DIM_W-1:0] dim_check32(input logic [31:0] v);
		logic [DIM_W-1:0] r;
		r = '0;
		if (!v[31] && v != 32'd0 && v <= 32'(MAX_DIM))
			r = v[DIM_W-1:0];
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] dim_check16(input logic [15:0] v);
		logic [DIM_W-1:0] r;
		r = '0;
		if (!v[15] && v != 16'd0 && 32'(v) <= 32'(MAX_DIM))
			r = v[DIM_W-1:0];
		return r;
	endfunction

endpackage

/* rtl/bmp24_stream_decoder_top.sv */
// bmp24_stream_decoder_top: byte-wide 24-bit bitmap parser emitting one beat per pixel or per header error
// depends on bmp24_pkg
//
//  channel  | dir | handshake        | content
//  ---------+-----+------------------+----------------------------------------------
//  s_*      | in  | s_tvalid/tready  | tdata file byte, tuser first byte of a file
//  m_*      | out | m_tvalid/tready  | tdata pixel fields, tlast last pixel, tuser status
//  cfg_*    | in  | cfg_we           | white level, no read-back
//
// one input beat per cycle while the result register is free or being drained; a result
// beat passes from the input register through the parse logic into the result register
// arst_n clears parse state to idle and white level to 255
// the input register keeps taking beats while the result register is free or
// being drained; a stalled result holds only the single parse stage behind it
module bmp24_stream_decoder_top
	import bmp24_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] file_byte
	input  logic               s_tuser,   // [0] first_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // red, green, blue, col, row, open_cell, open_total
	output logic               m_tlast,   // last_pixel
	output logic [2:0]         m_tuser,   // [2:0] status
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata  // white_level
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	// parse state
	logic [2:0]         phase_q;
	logic [31:0]        file_pos_q;
	logic [31:0]        word_accum_q;
	logic [31:0]        data_start_q;
	logic               header_kind_q;
	logic [DIM_W-1:0]   img_width_q;
	logic [DIM_W-1:0]   img_height_q;
	logic [COORD_W-1:0] cur_col_q;
	logic [COORD_W-1:0] cur_row_q;
	logic [1:0]         comp_index_q;
	logic [1:0]         pad_left_q;
	logic [15:0]        held_bytes_q;
	logic [COUNT_W-1:0] open_count_q;
	logic [7:0]         white_level_q;

	// next state
	logic [2:0]         phase_d;
	logic [31:0]        file_pos_d;
	logic [31:0]        word_accum_d;
	logic [31:0]        data_start_d;
	logic               header_kind_d;
	logic [DIM_W-1:0]   img_width_d;
	logic [DIM_W-1:0]   img_height_d;
	logic [COORD_W-1:0] cur_col_d;
	logic [COORD_W-1:0] cur_row_d;
	logic [1:0]         comp_index_d;
	logic [1:0]         pad_left_d;
	logic [15:0]        held_bytes_d;
	logic [COUNT_W-1:0] open_count_d;

	// result of this byte
	logic               emit;
	logic [7:0]         res_red, res_green, res_blue;
	logic [COORD_W-1:0] res_col, res_row;
	logic               res_open;
	logic [COUNT_W-1:0] res_total;
	logic               res_last;
	logic [2:0]         res_status;

	// result register
	logic               valid_s2;
	logic [7:0]         red_s2, green_s2, blue_s2;
	logic [COORD_W-1:0] col_s2, row_s2;
	logic               open_s2;
	logic [COUNT_W-1:0] total_s2;
	logic               last_s2;
	logic [2:0]         status_s2;

	logic out_free;
	logic consume;

	assign out_free = !valid_s2 || m_tready;
	assign consume  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || consume;

	always_comb begin
		logic [31:0]      pos;
		logic [15:0]      half;
		logic             failed;
		logic [2:0]       fail_code;
		logic             hdr_done;
		logic             do_pix;
		logic [DIM_W-1:0] col_inc;
		logic [DIM_W-1:0] row_inc;

		phase_d       = phase_q;
		file_pos_d    = file_pos_q;
		word_accum_d  = word_accum_q;
		data_start_d  = data_start_q;
		header_kind_d = header_kind_q;
		img_width_d   = img_width_q;
		img_height_d  = img_height_q;
		cur_col_d     = cur_col_q;
		cur_row_d     = cur_row_q;
		comp_index_d  = comp_index_q;
		pad_left_d    = pad_left_q;
		held_bytes_d  = held_bytes_q;
		open_count_d  = open_count_q;

		emit       = 1'b0;
		res_red    = '0;
		res_green  = '0;
		res_blue   = '0;
		res_col    = '0;
		res_row    = '0;
		res_open   = 1'b0;
		res_total  = '0;
		res_last   = 1'b0;
		res_status = ST_PIXEL;

		pos       = '0;
		half      = '0;
		failed    = 1'b0;
		fail_code = ST_PIXEL;
		hdr_done  = 1'b0;
		do_pix    = 1'b0;
		col_inc   = '0;
		row_inc   = '0;

		// first byte restarts everything but the white level
		if (first_s1) begin
			phase_d       = PH_HEADER;
			file_pos_d    = '0;
			word_accum_d  = '0;
			data_start_d  = '0;
			header_kind_d = 1'b0;
			img_width_d   = '0;
			img_height_d  = '0;
			cur_col_d     = '0;
			cur_row_d     = '0;
			comp_index_d  = '0;
			pad_left_d    = '0;
			held_bytes_d  = '0;
			open_count_d  = '0;
		end

		if (phase_d != PH_IDLE) begin
			pos = file_pos_d;
			if (file_pos_d != 32'hFFFF_FFFF)
				file_pos_d = file_pos_d + 32'd1;

			case (phase_d)
				PH_HEADER: begin
					word_accum_d = {byte_s1, word_accum_d[31:8]};
					half = word_accum_d[31:16];
					if (pos == 32'd0 && byte_s1 != MAGIC_B) begin
						failed = 1'b1; fail_code = ST_BAD_MAGIC;
					end else if (pos == 32'd1 && byte_s1 != MAGIC_M) begin
						failed = 1'b1; fail_code = ST_BAD_MAGIC;
					end else begin
						if (pos == 32'd13)
							data_start_d = word_accum_d;
						if (pos == 32'd17) begin
							if (word_accum_d == HDR_LONG)
								header_kind_d = 1'b1;
							else if (word_accum_d == HDR_SHORT)
								header_kind_d = 1'b0;
							else begin
								failed = 1'b1; fail_code = ST_BAD_HDR;
							end
						end
						if (!failed && pos > 32'd17) begin
							if (header_kind_d) begin
								if (pos == 32'd21)
									img_width_d = dim_check32(word_accum_d);
								if (pos == 32'd25)
									img_height_d = dim_check32(word_accum_d);
								if (pos == 32'd29 && half != BPP_24) begin
									failed = 1'b1; fail_code = ST_NOT_24BPP;
								end
								if (pos == 32'd33) begin
									if (word_accum_d != 32'd0) begin
										failed = 1'b1; fail_code = ST_COMPRESSED;
									end else
										hdr_done = 1'b1;
								end
							end else begin
								if (pos == 32'd19)
									img_width_d = dim_check16(half);
								if (pos == 32'd21)
									img_height_d = dim_check16(half);
								if (pos == 32'd25) begin
									if (half != BPP_24) begin
										failed = 1'b1; fail_code = ST_NOT_24BPP;
									end else
										hdr_done = 1'b1;
								end
							end
						end
					end
					// size check comes last, after bpp and (long header only) compression
					if (hdr_done) begin
						if (img_width_d == '0 || img_height_d == '0) begin
							failed = 1'b1; fail_code = ST_BAD_SIZE;
						end else
							phase_d = PH_SKIP;
					end
					if (failed) begin
						phase_d    = PH_IDLE;
						emit       = 1'b1;
						res_status = fail_code;
					end
				end
				PH_SKIP: begin
					if (pos >= data_start_d) begin
						phase_d = PH_PIXEL;
						do_pix  = 1'b1;
					end
				end
				PH_PIXEL: begin
					do_pix = 1'b1;
				end
				PH_PAD: begin
					if (pad_left_d != 2'd0)
						pad_left_d = pad_left_d - 2'd1;
					if (pad_left_d == 2'd0) begin
						cur_col_d = '0;
						cur_row_d = cur_row_d + COORD_W'(1);
						phase_d   = PH_PIXEL;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase

			// bytes arrive blue, green, red
			if (do_pix) begin
				case (comp_index_d)
					2'd0: begin
						held_bytes_d = {8'h00, byte_s1};
						comp_index_d = 2'd1;
					end
					2'd1: begin
						held_bytes_d = {byte_s1, held_bytes_d[7:0]};
						comp_index_d = 2'd2;
					end
					default: begin
						comp_index_d = 2'd0;
						res_open = (byte_s1 < white_level_q);
						if (res_open && open_count_d != OPEN_MAX)
							open_count_d = open_count_d + COUNT_W'(1);
						col_inc = {1'b0, cur_col_d} + DIM_W'(1);
						row_inc = {1'b0, cur_row_d} + DIM_W'(1);
						res_last = (row_inc == img_height_d) && (col_inc == img_width_d);
						emit       = 1'b1;
						res_red    = byte_s1;
						res_green  = held_bytes_d[15:8];
						res_blue   = held_bytes_d[7:0];
						res_col    = cur_col_d;
						res_row    = cur_row_d;
						res_total  = open_count_d;
						res_status = ST_PIXEL;
						if (res_last)
							phase_d = PH_IDLE;
						else if (col_inc >= img_width_d) begin
							// row padding to four bytes equals width mod 4
							pad_left_d = img_width_d[1:0];
							if (pad_left_d != 2'd0) begin
								phase_d   = PH_PAD;
								cur_col_d = col_inc[COORD_W-1:0];
							end else begin
								cur_col_d = '0;
								cur_row_d = cur_row_d + COORD_W'(1);
							end
						end else
							cur_col_d = col_inc[COORD_W-1:0];
					end
				endcase
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// white level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_level_q <= 8'd255;
		end else if (cfg_we) begin
			white_level_q <= cfg_wdata;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			file_pos_q    <= '0;
			word_accum_q  <= '0;
			data_start_q  <= '0;
			header_kind_q <= 1'b0;
			img_width_q   <= '0;
			img_height_q  <= '0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			comp_index_q  <= '0;
			pad_left_q    <= '0;
			held_bytes_q  <= '0;
			open_count_q  <= '0;
		end else if (consume) begin
			phase_q       <= phase_d;
			file_pos_q    <= file_pos_d;
			word_accum_q  <= word_accum_d;
			data_start_q  <= data_start_d;
			header_kind_q <= header_kind_d;
			img_width_q   <= img_width_d;
			img_height_q  <= img_height_d;
			cur_col_q     <= cur_col_d;
			cur_row_q     <= cur_row_d;
			comp_index_q  <= comp_index_d;
			pad_left_q    <= pad_left_d;
			held_bytes_q  <= held_bytes_d;
			open_count_q  <= open_count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume && emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && emit) begin
			red_s2    <= res_red;
			green_s2  <= res_green;
			blue_s2   <= res_blue;
			col_s2    <= res_col;
			row_s2    <= res_row;
			open_s2   <= res_open;
			total_s2  <= res_total;
			last_s2   <= res_last;
			status_s2 <= res_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, total_s2, open_s2, row_s2, col_s2, blue_s2, green_s2, red_s2};
	assign m_tlast  = last_s2;
	assign m_tuser  = status_s2;

endmodule
